// ===== rtl/kag_pkg.sv =====
// Shared types and constants for the key auto-repeat generator.
package kag_pkg;

   localparam int KEY_CODE_W  = 7;
   localparam int ELAPSED_W   = 16;
   localparam int TIMER_W     = 20;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_DELAY    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_INTERVAL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODIFIER_FIRST  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODIFIER_LAST   = 2'd3;

   localparam logic [TIMER_W-1:0]    REPEAT_DELAY_RESET    = 20'd8000;
   localparam logic [TIMER_W-1:0]    REPEAT_INTERVAL_RESET = 20'd800;
   localparam logic [KEY_CODE_W-1:0] MODIFIER_FIRST_RESET  = 7'd0;
   localparam logic [KEY_CODE_W-1:0] MODIFIER_LAST_RESET   = 7'd0;

   typedef struct packed {
      logic [KEY_CODE_W-1:0] key_code;
      logic                  pressed;
      logic [ELAPSED_W-1:0]  elapsed;
   } req_type;

   typedef struct packed {
      logic fire;
      logic was_modifier;
   } rsp_type;

   // A classified request waiting in the queue.
   typedef struct packed {
      logic [KEY_CODE_W-1:0] key_code;
      logic                  pressed;
      logic [ELAPSED_W-1:0]  elapsed;
      logic                  modifier;
      logic                  active;
   } item_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

// ===== rtl/kag_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kag_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/kag_front.sv =====
// Front end: accepts key reports, classifies them and queues them.
module kag_front #(
   parameter int KEY_COUNT = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  kag_pkg::req_type                  req_data,
   input  logic [kag_pkg::KEY_CODE_W-1:0]    mod_first,
   input  logic [kag_pkg::KEY_CODE_W-1:0]    mod_last,
   input  logic                              pop,
   output kag_pkg::head_type                 head
);
   import kag_pkg::*;

   localparam int QUEUE_DEPTH = 2;

   item_type    q_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   item_type    new_item;

   // Classification against the modifier range and the key count.
   always_comb begin
      new_item.key_code = req_data.key_code;
      new_item.pressed  = req_data.pressed;
      new_item.elapsed  = req_data.elapsed;
      new_item.modifier = (req_data.key_code >= mod_first) &&
                          (req_data.key_code <= mod_last);
      new_item.active   = !new_item.modifier &&
                          ({25'd0, req_data.key_code} < 32'(KEY_COUNT));
   end

   assign req_stall = (count_ff == 2'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

// ===== rtl/kag_back.sv =====
// Back end: hold timer update with forwarding and the response register.
module kag_back #(
   parameter int KEY_COUNT = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  kag_pkg::head_type              head,
   output logic                           pop,
   input  logic [kag_pkg::TIMER_W-1:0]    repeat_delay,
   input  logic [kag_pkg::TIMER_W-1:0]    repeat_interval,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output kag_pkg::rsp_type               rsp_data
);
   import kag_pkg::*;

   localparam int KEY_SPACE = 1 << KEY_CODE_W;
   localparam int DEPTH     = (KEY_COUNT < KEY_SPACE) ? KEY_COUNT : KEY_SPACE;
   localparam int AW        = $clog2(DEPTH);

   // Execute stage.
   logic               x_valid_ff, x_valid_in;
   item_type           x_item_ff;
   logic               x_done;
   logic               x_adv;

   // Last timer write, for forwarding over the RAM read latency.
   logic               last_we_ff;
   logic [AW-1:0]      last_idx_ff;
   logic [TIMER_W-1:0] last_val_ff;

   logic               valid_ff [DEPTH];

   logic               out_valid_ff, out_valid_in;
   rsp_type            out_data_ff;

   logic [AW-1:0]      raddr;
   logic [AW-1:0]      x_idx;
   logic [TIMER_W-1:0] rdata;
   logic [TIMER_W-1:0] timer;
   logic [TIMER_W:0]   sum;
   logic [TIMER_W-1:0] sat;
   logic [TIMER_W:0]   thresh;
   logic [TIMER_W-1:0] new_timer;
   logic               fire;
   logic               we;

   assign x_done = !out_valid_ff || !rsp_stall;
   assign x_adv  = !x_valid_ff || x_done;
   assign pop    = head.valid && x_adv;
   assign x_idx  = x_item_ff.key_code[AW-1:0];

   // A stalled item keeps re-reading its own entry; nothing is written meanwhile.
   assign raddr = x_adv ? head.item.key_code[AW-1:0] : x_idx;

   kag_ram #(
      .WIDTH (TIMER_W),
      .DEPTH (DEPTH)
   ) u_timer_ram (
      .clock (clock),
      .we    (we),
      .waddr (x_idx),
      .wdata (new_timer),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      if (last_we_ff && (last_idx_ff == x_idx)) begin
         timer = last_val_ff;
      end else if (valid_ff[x_idx]) begin
         timer = rdata;
      end else begin
         timer = '0;
      end

      sum    = {1'b0, timer} + {{(TIMER_W - ELAPSED_W + 1){1'b0}}, x_item_ff.elapsed};
      sat    = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
      thresh = {1'b0, repeat_delay} + {1'b0, repeat_interval};

      priority if (!x_item_ff.pressed) begin
         new_timer = '0;
         fire      = 1'b0;
      end else if (timer == '0) begin
         new_timer = {{(TIMER_W - ELAPSED_W){1'b0}}, x_item_ff.elapsed};
         fire      = 1'b1;
      end else if ({1'b0, sat} > thresh) begin
         new_timer = repeat_delay;
         fire      = 1'b1;
      end else begin
         new_timer = sat;
         fire      = 1'b0;
      end
   end

   assign we = x_valid_ff && x_done && x_item_ff.active;

   always_comb begin
      x_valid_in   = x_adv ? head.valid : x_valid_ff;
      out_valid_in = (x_valid_ff && x_done) || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         last_we_ff   <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         x_valid_ff   <= x_valid_in;
         out_valid_ff <= out_valid_in;
         if (we) begin
            last_we_ff      <= 1'b1;
            valid_ff[x_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         x_item_ff <= head.item;
      end
      if (we) begin
         last_idx_ff <= x_idx;
         last_val_ff <= new_timer;
      end
      if (x_valid_ff && x_done) begin
         out_data_ff.fire         <= x_item_ff.active && fire;
         out_data_ff.was_modifier <= x_item_ff.modifier;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/key_autorepeat_generator.sv =====
// Top level of the key auto-repeat generator.
// The block takes one key report per request (key code, pressed flag, time
// since the last report in 1/16 ms) and answers each with exactly one
// response: fire when the key press should be emitted now, and was_modifier
// when the key falls in the configured modifier range. It sustains one
// request per clock cycle while the response side does not stall; each
// request passes through a queue entry, the execute stage and the response
// register. The rate is set by the read-modify-write of the hold timer RAM
// (one read port, one write port), which finishes one key per cycle while
// not stalled, with a forwarding register covering the registered read.
// A two-entry queue sits between the classifying front end and the timer
// back end, and a response register holds a finished response while the
// response side stalls. Timers start at zero right after reset through
// per-key valid bits, so there is no clearing pass. The user must write
// configuration only while the block is idle; the block does not enforce it.
module key_autorepeat_generator #(
   parameter int KEY_COUNT = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  kag_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output kag_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [kag_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kag_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import kag_pkg::*;

   // Configuration registers.
   logic [TIMER_W-1:0]    repeat_delay_ff;
   logic [TIMER_W-1:0]    repeat_interval_ff;
   logic [KEY_CODE_W-1:0] modifier_first_ff;
   logic [KEY_CODE_W-1:0] modifier_last_ff;

   head_type head;
   logic     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_delay_ff    <= REPEAT_DELAY_RESET;
         repeat_interval_ff <= REPEAT_INTERVAL_RESET;
         modifier_first_ff  <= MODIFIER_FIRST_RESET;
         modifier_last_ff   <= MODIFIER_LAST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REPEAT_DELAY: begin
               repeat_delay_ff <= csr_wdata[TIMER_W-1:0];
            end
            CSR_REPEAT_INTERVAL: begin
               repeat_interval_ff <= csr_wdata[TIMER_W-1:0];
            end
            CSR_MODIFIER_FIRST: begin
               modifier_first_ff <= csr_wdata[KEY_CODE_W-1:0];
            end
            CSR_MODIFIER_LAST: begin
               modifier_last_ff <= csr_wdata[KEY_CODE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The front end classifies each request as it is accepted, so the back end
   // never looks at the modifier range.
   kag_front #(
      .KEY_COUNT (KEY_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .mod_first (modifier_first_ff),
      .mod_last  (modifier_last_ff),
      .pop       (pop),
      .head      (head)
   );

   // The back end pulls one request per cycle whenever its result can move on.
   kag_back #(
      .KEY_COUNT (KEY_COUNT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .repeat_delay    (repeat_delay_ff),
      .repeat_interval (repeat_interval_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

`ifndef SYNTH
   // A suppressed modifier key can never fire.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.fire && rsp_data.was_modifier))
      else $error("response both fires and reports a modifier");

   // The cycle after a reset edge the pipeline is empty and ready.
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   // A request popped from the queue while the response side stalls must
   // not overrun a waiting response.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("waiting response was lost");
`endif

endmodule
